[rtl/kmp_pkg.sv]
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared types and constants for the streaming KMP substring search.
// ----------------------------------------------------------------------------
`default_nettype none

package kmp_pkg;

  // Bytes held by the two pattern registers together
  localparam int PAT_BYTES = 16;
  localparam int PAT_IDX_W = 4;
  localparam int PAT_W     = 8 * PAT_BYTES;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int LEN_W      = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW  = 2'd0,
    REG_PATTERN_HIGH = 2'd1,
    REG_PATTERN_LEN  = 2'd2,
    REG_UNUSED       = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUILD_INIT,
    ST_BUILD_STEP,
    ST_BUILD_WAIT,
    ST_MATCH_STEP,
    ST_MATCH_WAIT,
    ST_EMIT
  } kmp_state_t;

  function automatic logic [7:0] pat_byte(input logic [PAT_W-1:0] pat,
                                          input logic [PAT_IDX_W-1:0] idx);
    pat_byte = pat[idx*8 +: 8];
  endfunction

endpackage

`default_nettype wire

[rtl/kmp_ram.sv]
// ----------------------------------------------------------------------------
// kmp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/kmp_substring_search.sv]
// ----------------------------------------------------------------------------
// kmp_substring_search
// Streams text bytes against a configured pattern and reports the start of
// the first match, or not found when the text ends without one.
// ----------------------------------------------------------------------------
//
//  channel | direction | payload
//  --------+-----------+---------------------------------------------------
//  in_     | sink      | tdata = text_byte, tuser = first_of_text, tlast
//  out_    | source    | tdata = match_start, tuser = found
//  cfg_    | sink      | index 0 pattern_low, 1 pattern_high, 2 length
//
// A byte is accepted in the idle state and compared in the match step; each
// failure link followed adds a failure table RAM read and a repeat compare.
// The first byte after a configuration write first rebuilds the table:
// an init step, a step per pattern byte after the first, and a RAM read and
// a repeat step per link followed. A result then waits in the output register.
// in_tready is high only while no byte is in progress; reset restores the
// reset configuration and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_substring_search #(
  parameter int MAX_PATTERN   = 16,
  parameter int POSITION_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,

  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [7:0]                     in_tdata,   // [7:0] text_byte
  input  wire logic [0:0]                     in_tuser,   // [0] first_of_text
  input  wire logic                           in_tlast,

  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic      [15:0]                    out_tdata,  // [15:0] match_start
  output logic      [0:0]                     out_tuser,  // [0] found

  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [kmp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kmp_pkg::CFG_DATA_W-1:0] cfg_data
);

  import kmp_pkg::*;

  localparam int CAP  = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;
  localparam int CW   = $clog2(CAP + 1);
  localparam int AW   = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int PB   = POSITION_BITS;

  kmp_state_t          state_r, state_nxt;
  logic [PAT_W-1:0]    pattern_r, pattern_nxt;
  logic [LEN_W-1:0]    length_r, length_nxt;
  logic                table_ready_r, table_ready_nxt;
  logic [CW-1:0]       matched_r, matched_nxt;
  logic [PB-1:0]       pos_r, pos_nxt;
  logic                done_r, done_nxt;
  logic [7:0]          byte_r, byte_nxt;
  logic                last_r, last_nxt;
  logic [CW-1:0]       i_r, i_nxt;
  logic [CW-1:0]       k_r, k_nxt;
  logic                res_found_r, res_found_nxt;
  logic [15:0]         res_start_r, res_start_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_found_r, out_found_nxt;
  logic [15:0]         out_start_r, out_start_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [AW-1:0]       ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [AW-1:0]       ram_rdata;

  logic [CW-1:0]       eff_len;
  logic [7:0]          pk, pi, pj;
  logic [CW-1:0]       k_adv, j_adv;
  logic [PB-1:0]       start_pos;

  kmp_ram #(
    .WIDTH (AW),
    .DEPTH (CAP)
  ) u_fail_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Length 0 counts as 1, anything above the storage saturates
  always_comb begin
    if (length_r == '0) begin
      eff_len = CW'(1);
    end else if (int'(length_r) > CAP) begin
      eff_len = CW'(CAP);
    end else begin
      eff_len = CW'(length_r);
    end
  end

  assign pk        = pat_byte(pattern_r, PAT_IDX_W'(k_r));
  assign pi        = pat_byte(pattern_r, PAT_IDX_W'(i_r));
  assign pj        = pat_byte(pattern_r, PAT_IDX_W'(matched_r));
  assign k_adv     = (pk == pi) ? k_r + CW'(1) : k_r;
  assign j_adv     = (pj == byte_r) ? matched_r + CW'(1) : matched_r;
  assign start_pos = pos_r + PB'(1) - PB'(eff_len);

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_start_r;
  assign out_tuser  = out_found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      pattern_r     <= '0;
      length_r      <= LEN_W'(1);
      table_ready_r <= 1'b0;
      matched_r     <= '0;
      pos_r         <= '0;
      done_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pattern_r     <= pattern_nxt;
      length_r      <= length_nxt;
      table_ready_r <= table_ready_nxt;
      matched_r     <= matched_nxt;
      pos_r         <= pos_nxt;
      done_r        <= done_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r      <= byte_nxt;
    last_r      <= last_nxt;
    i_r         <= i_nxt;
    k_r         <= k_nxt;
    res_found_r <= res_found_nxt;
    res_start_r <= res_start_nxt;
    out_found_r <= out_found_nxt;
    out_start_r <= out_start_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    pattern_nxt     = pattern_r;
    length_nxt      = length_r;
    table_ready_nxt = table_ready_r;
    matched_nxt     = matched_r;
    pos_nxt         = pos_r;
    done_nxt        = done_r;
    byte_nxt        = byte_r;
    last_nxt        = last_r;
    i_nxt           = i_r;
    k_nxt           = k_r;
    res_found_nxt   = res_found_r;
    res_start_nxt   = res_start_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_found_nxt   = out_found_r;
    out_start_nxt   = out_start_r;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = '0;
    ram_raddr       = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          byte_nxt = in_tdata;
          last_nxt = in_tlast;
          if (in_tuser[0]) begin
            matched_nxt = '0;
            pos_nxt     = '0;
            done_nxt    = 1'b0;
          end else if (matched_r >= eff_len) begin
            matched_nxt = '0;
          end
          if (!table_ready_r) begin
            state_nxt = ST_BUILD_INIT;
          end else if (in_tuser[0] || !done_r) begin
            state_nxt = ST_MATCH_STEP;
          end
        end
      end

      ST_BUILD_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '0;
        i_nxt     = CW'(1);
        k_nxt     = '0;
        if (eff_len == CW'(1)) begin
          matched_nxt     = '0;
          table_ready_nxt = 1'b1;
          state_nxt       = done_r ? ST_IDLE : ST_MATCH_STEP;
        end else begin
          state_nxt = ST_BUILD_STEP;
        end
      end

      ST_BUILD_STEP: begin
        if (k_r != '0 && pk != pi) begin
          // follow the link of the shorter border
          ram_raddr = AW'(k_r - CW'(1));
          state_nxt = ST_BUILD_WAIT;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = AW'(i_r);
          ram_wdata = AW'(k_adv);
          k_nxt     = k_adv;
          i_nxt     = i_r + CW'(1);
          if (i_r + CW'(1) == eff_len) begin
            matched_nxt     = '0;
            table_ready_nxt = 1'b1;
            state_nxt       = done_r ? ST_IDLE : ST_MATCH_STEP;
          end
        end
      end

      ST_BUILD_WAIT: begin
        k_nxt     = CW'(ram_rdata);
        state_nxt = ST_BUILD_STEP;
      end

      ST_MATCH_STEP: begin
        if (matched_r != '0 && pj != byte_r) begin
          ram_raddr = AW'(matched_r - CW'(1));
          state_nxt = ST_MATCH_WAIT;
        end else if (j_adv == eff_len) begin
          res_found_nxt = 1'b1;
          res_start_nxt = 16'(start_pos);
          matched_nxt   = '0;
          done_nxt      = 1'b1;
          state_nxt     = ST_EMIT;
        end else if (last_r) begin
          res_found_nxt = 1'b0;
          res_start_nxt = '0;
          matched_nxt   = '0;
          done_nxt      = 1'b1;
          state_nxt     = ST_EMIT;
        end else begin
          matched_nxt = j_adv;
          pos_nxt     = pos_r + PB'(1);
          state_nxt   = ST_IDLE;
        end
      end

      ST_MATCH_WAIT: begin
        matched_nxt = CW'(ram_rdata);
        state_nxt   = ST_MATCH_STEP;
      end

      ST_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_start_nxt = res_start_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LOW: begin
          pattern_nxt[CFG_DATA_W-1:0] = cfg_data;
          table_ready_nxt             = 1'b0;
        end
        REG_PATTERN_HIGH: begin
          pattern_nxt[PAT_W-1:CFG_DATA_W] = cfg_data;
          table_ready_nxt                 = 1'b0;
        end
        REG_PATTERN_LEN: begin
          length_nxt      = cfg_data[LEN_W-1:0];
          table_ready_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/kmp_checker.sv]
// ----------------------------------------------------------------------------
// kmp_checker
// Port-level checks for the KMP substring search, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic [0:0]  out_tuser
);

  // a result waiting for the sink keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 16'd0)
    else $error("not-found result carries a nonzero start");

  // an open input stays open until an item arrives
  a_ready_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && !in_tvalid |=> in_tready)
    else $error("input closed with no item accepted");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present right after reset");

endmodule

bind kmp_substring_search kmp_checker u_kmp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
